// ===== rtl/timestamped_sample_interpolator_unit_assert.svh =====
// assertion macros for the sample interpolator
`ifndef TIMESTAMPED_SAMPLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define TIMESTAMPED_SAMPLE_INTERPOLATOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TSI_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define TSI_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/tsi_pkg.sv =====
// shared types and constants of the sample interpolator
`default_nettype none
package tsi_pkg;
  localparam int unsigned LagW = 20;
  localparam logic [LagW-1:0] LagReset = 20'd4000;
  localparam logic [0:0] RegLag = 1'b0;
  localparam logic ReqAdd = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] sample_count;
    logic [63:0] time_stamp;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        hit;
    logic [6:0]  held_points;
    logic        overflow_drop;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StFlushRd,
    StFlushChk,
    StWrite,
    StQryRd,
    StQryChk,
    StMulA,
    StMulB,
    StDiv,
    StOut
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/timestamped_sample_interpolator_unit.sv =====
// sample interpolator top level: sample ring memories, sequencer, multiplier and divider
// add: drops samples older than twice the lag from the oldest end, then writes the new one
// query: reads the samples in order, then multiplies and divides on a bracketing pair
// throughput: one request at a time, accepted only once the previous result is taken; the
// pair scan through the ring memory port and the 64-step restoring divider bound it
// reset: ring empty, lag register 4000; ring contents are not cleared and never read unwritten
`default_nettype none
module timestamped_sample_interpolator_unit #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire tsi_pkg::req_t            in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output tsi_pkg::rsp_t                 out_data_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  tsi_pkg::state_e state_q, state_d;
  logic [tsi_pkg::LagW-1:0] lag_q;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] idx_q, idx_d;
  tsi_pkg::req_t req_q;
  logic ovf_q, ovf_d;
  logic out_valid_q;
  tsi_pkg::rsp_t rsp_q;

  logic [63:0] cmem [RING_DEPTH];
  logic [63:0] tmem [RING_DEPTH];
  logic [AW-1:0] raddr, waddr;
  logic rd_en, wr_en;
  logic [63:0] rc_q, rt_q;
  logic [63:0] ca_q, ta_q;
  logic [63:0] tq;
  logic [63:0] dc_q, dt_q, span_q, prod_q;
  logic [31:0] pp_q [4];
  logic [63:0] pp_lo;
  logic [63:0] quo_q, rem_q;
  logic [6:0] dcnt_q;
  logic first_q;
  logic hit_q;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [FW-1:0] off);
    logic [FW:0] s;
    s = {{(FW+1-AW){1'b0}}, base} + {1'b0, off};
    if (s >= (FW+1)'(RING_DEPTH)) s = s - (FW+1)'(RING_DEPTH);
    return s[AW-1:0];
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tsi_pkg::RegLag) ? {{(32-tsi_pkg::LagW){1'b0}}, lag_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= tsi_pkg::LagReset;
    end else if (psel && penable && pwrite && paddr[2] == tsi_pkg::RegLag) begin
      lag_q <= pwdata[tsi_pkg::LagW-1:0];
    end
  end

  assign in_ready_o = (state_q == tsi_pkg::StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;
  assign tq = req_q.time_stamp - {44'd0, lag_q};

  // memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmem[waddr] <= req_q.sample_count;
      tmem[waddr] <= req_q.time_stamp;
    end
    if (rd_en) begin
      rc_q <= cmem[raddr];
      rt_q <= tmem[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsi_pkg::StIdle:
        if (in_valid_i && in_ready_o)
          state_d = (in_data_i.req_type == tsi_pkg::ReqAdd) ? tsi_pkg::StFlushRd
                                                            : tsi_pkg::StQryRd;
      tsi_pkg::StFlushRd:
        state_d = (fill_q == '0) ? tsi_pkg::StWrite : tsi_pkg::StFlushChk;
      tsi_pkg::StFlushChk:
        state_d = ((req_q.time_stamp - rt_q) > {43'd0, lag_q, 1'b0}) ? tsi_pkg::StFlushRd
                                                                     : tsi_pkg::StWrite;
      tsi_pkg::StWrite: state_d = tsi_pkg::StOut;
      tsi_pkg::StQryRd:
        state_d = (idx_q >= fill_q) ? tsi_pkg::StOut : tsi_pkg::StQryChk;
      tsi_pkg::StQryChk:
        if (first_q) state_d = tsi_pkg::StQryRd;
        else if (ta_q <= tq && tq <= rt_q)
          state_d = (rt_q == ta_q) ? tsi_pkg::StOut : tsi_pkg::StMulA;
        else state_d = tsi_pkg::StQryRd;
      tsi_pkg::StMulA: state_d = tsi_pkg::StMulB;
      tsi_pkg::StMulB: state_d = tsi_pkg::StDiv;
      tsi_pkg::StDiv: if (dcnt_q == 7'd63) state_d = tsi_pkg::StOut;
      tsi_pkg::StOut: state_d = tsi_pkg::StIdle;
      default: state_d = tsi_pkg::StIdle;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = oldest_q;
    wr_en = 1'b0;
    waddr = slot(oldest_q, fill_q);
    oldest_d = oldest_q;
    fill_d = fill_q;
    idx_d = idx_q;
    ovf_d = ovf_q;
    unique case (state_q)
      tsi_pkg::StIdle: begin
        idx_d = '0;
        ovf_d = 1'b0;
      end
      tsi_pkg::StFlushRd: rd_en = 1'b1;
      tsi_pkg::StFlushChk:
        if ((req_q.time_stamp - rt_q) > {43'd0, lag_q, 1'b0}) begin
          oldest_d = slot(oldest_q, FW'(1));
          fill_d = fill_q - FW'(1);
        end
      tsi_pkg::StWrite: begin
        wr_en = 1'b1;
        if (fill_q >= FW'(RING_DEPTH)) begin
          // full ring: overwrite oldest slot and advance
          waddr = oldest_q;
          oldest_d = slot(oldest_q, FW'(1));
          ovf_d = 1'b1;
        end else begin
          fill_d = fill_q + FW'(1);
        end
      end
      tsi_pkg::StQryRd:
        if (idx_q < fill_q) begin
          rd_en = 1'b1;
          raddr = slot(oldest_q, idx_q);
          idx_d = idx_q + FW'(1);
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsi_pkg::StIdle;
      oldest_q <= '0;
      fill_q <= '0;
      idx_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
      first_q <= 1'b1;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      oldest_q <= oldest_d;
      fill_q <= fill_d;
      idx_q <= idx_d;
      ovf_q <= ovf_d;
      if (state_q == tsi_pkg::StIdle) first_q <= 1'b1;
      else if (state_q == tsi_pkg::StQryChk) first_q <= 1'b0;
      if (state_q == tsi_pkg::StIdle) hit_q <= 1'b0;
      else if (state_q == tsi_pkg::StQryChk && !first_q && ta_q <= tq && tq <= rt_q)
        hit_q <= 1'b1;
      if (state_q == tsi_pkg::StOut) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // low 64 bits of the product from one 32x32 full product and two truncated cross terms
  assign pp_lo = 64'(dc_q[31:0]) * 64'(dt_q[31:0]);

  // datapath: pair registers, split multiplier, restoring divider
  always_ff @(posedge clk_i) begin
    if (state_q == tsi_pkg::StIdle && in_valid_i && in_ready_o) req_q <= in_data_i;
    if (state_q == tsi_pkg::StQryChk) begin
      // keep the older sample of a bracketing pair, else move on to the sample just read
      if (first_q || !(ta_q <= tq && tq <= rt_q)) begin
        ca_q <= rc_q;
        ta_q <= rt_q;
      end
      dc_q <= rc_q - ca_q;
      dt_q <= tq - ta_q;
      span_q <= rt_q - ta_q;
    end
    if (state_q == tsi_pkg::StMulA) begin
      pp_q[0] <= pp_lo[31:0];
      pp_q[1] <= pp_lo[63:32];
      pp_q[2] <= 32'(dc_q[63:32] * dt_q[31:0]);
      pp_q[3] <= 32'(dc_q[31:0] * dt_q[63:32]);
    end
    if (state_q == tsi_pkg::StMulB) begin
      prod_q <= {pp_q[1] + pp_q[2] + pp_q[3], pp_q[0]};
      quo_q <= '0;
      rem_q <= '0;
      dcnt_q <= '0;
    end
    if (state_q == tsi_pkg::StDiv) begin
      if ({rem_q[62:0], prod_q[63]} >= span_q || rem_q[63]) begin
        rem_q <= {rem_q[62:0], prod_q[63]} - span_q;
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], prod_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
      prod_q <= {prod_q[62:0], 1'b0};
      dcnt_q <= dcnt_q + 7'd1;
    end
    if (state_q == tsi_pkg::StOut) begin
      rsp_q.held_points <= 7'(fill_q);
      rsp_q.overflow_drop <= ovf_q;
      rsp_q.hit <= hit_q;
      rsp_q.value <= !hit_q ? 64'd0 : (rt_q == ta_q) ? ca_q : ca_q + quo_q;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tsi_checker.sv =====
// port-level checker for the sample interpolator, bound to the top level
`default_nettype none
`include "timestamped_sample_interpolator_unit_assert.svh"
module tsi_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire tsi_pkg::rsp_t out_data_o
);
  `TSI_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TSI_ASSERT_IMP(a_no_accept_with_result, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TSI_ASSERT_IMP(a_fill_range, clk_i, rst_ni, out_valid_o, out_data_o.held_points <= 7'd64)
  `TSI_ASSERT_IMP(a_hit_needs_two, clk_i, rst_ni, out_valid_o && out_data_o.hit,
                  out_data_o.held_points >= 7'd2 && !out_data_o.overflow_drop)
  `TSI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind timestamped_sample_interpolator_unit tsi_checker u_tsi_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);
`default_nettype wire

// ===== tb/sv/tb_timestamped_sample_interpolator_unit.sv =====
// testbench of the sample interpolator: directed and random add and query traffic checked against a predictor
`default_nettype none
module tb_timestamped_sample_interpolator_unit;
  localparam int unsigned Depth = 64;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned Settle = 300;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  tsi_pkg::req_t in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  tsi_pkg::rsp_t out_data_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  timestamped_sample_interpolator_unit #(.RING_DEPTH(Depth)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [63:0]              ring_count [Depth];
  logic [63:0]              ring_time  [Depth];
  logic [5:0]               ring_head;
  int unsigned              ring_fill;
  logic [tsi_pkg::LagW-1:0] lag_value;

  tsi_pkg::req_t pending_req[$];
  tsi_pkg::rsp_t expected_rsp[$];
  int unsigned errors, accepted_cnt, checked_cnt, hit_cnt, drop_cnt, cycles, issued_cnt;
  int unsigned send_gap, recv_gap, hold_left;
  bit          no_idle, hold_req;
  logic [63:0] cur_t, cur_c;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tsi_pkg::rsp_t predict(tsi_pkg::req_t rq);
    tsi_pkg::rsp_t r;
    logic [63:0]   t, ta, tb, ca, cb, span;
    logic [5:0]    ia, ib;
    bit            found;
    r = '0;
    found = 1'b0;
    if (rq.req_type == tsi_pkg::ReqAdd) begin
      while (ring_fill > 0 &&
             (rq.time_stamp - ring_time[ring_head]) > {43'd0, lag_value, 1'b0}) begin
        ring_head++;
        ring_fill--;
      end
      if (ring_fill >= Depth) begin
        ring_head++;
        ring_fill--;
        r.overflow_drop = 1'b1;
      end
      ia = ring_head + 6'(ring_fill);
      ring_count[ia] = rq.sample_count;
      ring_time[ia] = rq.time_stamp;
      ring_fill++;
    end else begin
      t = rq.time_stamp - {44'd0, lag_value};
      for (int unsigned i = 0; i + 1 < ring_fill && !found; i++) begin
        ia = ring_head + 6'(i);
        ib = ring_head + 6'(i + 1);
        ta = ring_time[ia];
        tb = ring_time[ib];
        if (ta <= t && t <= tb) begin
          found = 1'b1;
          ca = ring_count[ia];
          cb = ring_count[ib];
          span = tb - ta;
          r.hit = 1'b1;
          if (span == 64'd0) r.value = ca;
          else r.value = ca + ((cb - ca) * (t - ta)) / span;
        end
      end
    end
    r.held_points = 7'(ring_fill);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at result %0d: got %h, expected %h", what, checked_cnt, got, want);
    errors++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap = 0;
    end else begin
      logic v;
      v = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_rsp.push_back(predict(in_data_i));
        accepted_cnt++;
        v = 1'b0;
      end
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_req.size() > 0) begin
          in_data_i <= pending_req[0];
          pending_req.delete(0);
          issued_cnt++;
          v = 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 13);
        end
      end
      in_valid_i <= v;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      logic r;
      tsi_pkg::rsp_t want;
      r = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          flag_mismatch("unexpected result", out_data_o.value, 64'd0);
        end else begin
          want = expected_rsp[0];
          expected_rsp.delete(0);
          if (out_data_o.value !== want.value)
            flag_mismatch("value", out_data_o.value, want.value);
          if (out_data_o.hit !== want.hit)
            flag_mismatch("hit", 64'(out_data_o.hit), 64'(want.hit));
          if (out_data_o.held_points !== want.held_points)
            flag_mismatch("held_points", 64'(out_data_o.held_points), 64'(want.held_points));
          if (out_data_o.overflow_drop !== want.overflow_drop)
            flag_mismatch("overflow_drop", 64'(out_data_o.overflow_drop),
                          64'(want.overflow_drop));
          hit_cnt += want.hit;
          drop_cnt += want.overflow_drop;
        end
        checked_cnt++;
        r = 1'b0;
        recv_gap = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 800;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (!r) begin
        if (recv_gap > 0) recv_gap--;
        else r = 1'b1;
      end
      out_ready_i <= r;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == {tsi_pkg::RegLag, 2'b00}) lag_value = data[tsi_pkg::LagW-1:0];
  endtask

  // wait until every transfer has come back, then let the block settle
  task automatic drain();
    while (pending_req.size() > 0 || issued_cnt != checked_cnt || expected_rsp.size() > 0)
      @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic push(logic kind, logic [63:0] cnt, logic [63:0] ts);
    tsi_pkg::req_t rq;
    rq.req_type = kind;
    rq.sample_count = cnt;
    rq.time_stamp = ts;
    pending_req.push_back(rq);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_traffic(int unsigned n);
    int unsigned mode, stride;
    logic [63:0] ts;
    stride = (lag_value == 0) ? 2 : 32'(lag_value) / 64 + 2;
    for (int unsigned k = 0; k < n; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        cur_t += 64'($urandom_range(0, stride));
        cur_c += ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 1000));
        push(tsi_pkg::ReqAdd, cur_c, cur_t);
      end else if (mode < 60) begin
        // wild or stale timestamp, flushes the ring on a wrapped difference
        cur_t = ($urandom_range(0, 1) == 0) ? rand64()
                                            : cur_t - 64'($urandom_range(1, 3 * stride));
        push(tsi_pkg::ReqAdd, rand64(), cur_t);
      end else if (mode < 95) begin
        ts = cur_t + {44'd0, lag_value} - 64'($urandom_range(0, 40 * stride));
        push(tsi_pkg::ReqQuery, rand64(), ts);
      end else begin
        push(tsi_pkg::ReqQuery, rand64(), rand64());
      end
    end
  endtask

  initial begin
    logic [31:0] lag_set [5];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    issued_cnt = 0;
    hit_cnt = 0;
    drop_cnt = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    ring_head = '0;
    ring_fill = 0;
    lag_value = tsi_pkg::LagReset;
    cur_t = 64'd100000;
    cur_c = 64'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ring, single sample, zero interval, extremes, wraps
    push(tsi_pkg::ReqQuery, '1, 64'd4100);
    push(tsi_pkg::ReqAdd, 64'd0, 64'd100);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd4100);
    push(tsi_pkg::ReqAdd, '1, 64'd100);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd4100);
    push(tsi_pkg::ReqAdd, 64'd1000, 64'd1100);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd4600);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd5100);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd5101);
    push(tsi_pkg::ReqAdd, 64'h8000_0000_0000_0000, 64'd2100);
    push(tsi_pkg::ReqQuery, '1, 64'd5600);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd0);
    push(tsi_pkg::ReqQuery, 64'd0, '1);
    push(tsi_pkg::ReqAdd, 64'd5, 64'd0);
    push(tsi_pkg::ReqAdd, 64'd7, 64'd8000);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd8000);
    push(tsi_pkg::ReqAdd, 64'd9, '1);
    push(tsi_pkg::ReqAdd, '1, 64'hFFFF_FFFF_FFFF_FFF0);
    push(tsi_pkg::ReqQuery, 64'd0, 64'hFFFF_FFFF_FFFF_FFF8 + 64'd4000);
    push(tsi_pkg::ReqQuery, 64'd0, 64'd3999);
    drain();

    // out-of-range index is ignored
    reg_write(3'd4, 32'd7);
    lag_set = '{32'd0, 32'd1000000, 32'hFFFF_FFFF, 32'd0, 32'd4000};
    lag_set[3] = $urandom_range(1, 300);
    for (int p = 0; p < 5; p++) begin
      reg_write({tsi_pkg::RegLag, 2'b00}, lag_set[p]);
      no_idle = (p == 2);
      if (p == 1) hold_req = 1'b1;
      random_traffic(276);
      drain();
    end

    $display("ran %0d transfers, %0d results checked, %0d query hits, %0d overflow drops",
             accepted_cnt, checked_cnt, hit_cnt, drop_cnt);
    $display("covered lag settings zero, maximum, masked wide write and random, with stalls");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/tsi_pkg.sv
rtl/timestamped_sample_interpolator_unit.sv
rtl/tsi_checker.sv
tb/sv/tb_timestamped_sample_interpolator_unit.sv
